FILE: design/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

  // Defaults
  localparam int unsigned SLOTS_DEF = 16;
  localparam logic [9:0] AGE_RESET = 10'd20;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Engine states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOD,
    ST_DONE
  } state_t;

  // One request as it travels from the front queue to the engine
  typedef struct packed {
    logic        req_type;
    logic [3:0]  slot;
    logic [15:0] job_id;
    logic [15:0] arrival_time;
    logic [7:0]  start_priority;
    logic [15:0] burst_length;
  } req_t;

  // One result item
  typedef struct packed {
    logic        frame_valid;
    logic [15:0] frame_job;
    logic [15:0] frame_arrival;
    logic [31:0] frame_start;
    logic [31:0] frame_end;
    logic [31:0] frame_length;
    logic        running_valid;
    logic [15:0] running_job;
    logic        all_done;
  } res_t;

  // Remainder unit control
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [9:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic       done;
    logic [9:0] rem;
  } rem_rsp_t;

endpackage

FILE: design/pps_front.sv
`timescale 1ns / 1ps

// Two-entry request queue between the input port and the engine
module pps_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  pps_pkg::req_t req_in,
  output logic          q_valid,
  input  logic          q_pop,
  output pps_pkg::req_t q_data
);

  pps_pkg::req_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= req_in;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: design/pps_rem.sv
`timescale 1ns / 1ps

// 32-bit by 10-bit remainder, four dividend bits per cycle
module pps_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  pps_pkg::rem_req_t req,
  output pps_pkg::rem_rsp_t rsp
);

  logic [31:0] div_r;
  logic [9:0]  den_r;
  logic [9:0]  r_r, r_nxt;
  logic [3:0]  cnt_r;
  logic        done_r;

  // Four restoring steps
  always_comb begin
    logic [10:0] t;
    r_nxt = r_r;
    for (int k = 0; k < 4; k++) begin
      t = {r_nxt, div_r[31-k]};
      if (t >= {1'b0, den_r}) t = t - {1'b0, den_r};
      r_nxt = t[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.dividend;
      den_r <= req.divisor;
      r_r   <= 10'd0;
    end else if (cnt_r != 4'd0) begin
      div_r <= {div_r[27:0], 4'd0};
      r_r   <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 4'd1);
      if (req.start) cnt_r <= 4'd8;
      else if (cnt_r != 4'd0) cnt_r <= cnt_r - 4'd1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = r_r;

endmodule

FILE: design/pps_back.sv
`timescale 1ns / 1ps

// Scheduling engine: job table, per-slot aging and selection scan, result register
module pps_back #(
  parameter int unsigned JOB_SLOTS = pps_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [9:0]    cfg_wdata,
  input  logic          q_valid,
  output logic          q_pop,
  input  pps_pkg::req_t q_data,
  output logic          out_valid,
  input  logic          out_pop,
  output pps_pkg::res_t out_data
);

  localparam int unsigned IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

  // Job table
  logic [JOB_SLOTS-1:0] used_r;
  logic [15:0] job_r  [JOB_SLOTS];
  logic [15:0] arr_r  [JOB_SLOTS];
  logic [7:0]  pri_r  [JOB_SLOTS];
  logic [15:0] left_r [JOB_SLOTS];

  logic [9:0]  period_r;
  logic [31:0] now_r;
  logic        cur_v_r;
  logic [IW-1:0] cur_slot_r;
  logic [31:0] began_r;

  pps_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] idx_r;

  // Scan accumulators
  logic          found_r, pending_r;
  logic [IW-1:0] b_slot_r;
  logic [7:0]    b_pri_r;
  logic [15:0]   b_arr_r, b_job_r;
  logic [15:0]   c_job_r, c_arr_r;

  logic          res_v_r;
  pps_pkg::res_t res_r;

  pps_pkg::rem_req_t rq;
  pps_pkg::rem_rsp_t rs;

  pps_rem u_rem (.clk(clk), .rst_n(rst_n), .req(rq), .rsp(rs));

  // Entry under scan
  logic        e_used;
  logic [15:0] e_job, e_arr, e_left;
  logic [7:0]  e_pri, e_pri_aged;
  logic [31:0] e_arr32;
  logic        need_age, eval_en, last, out_free;
  logic        ready, waiting, better, load_ok;
  logic        frame, finished;
  logic        load_en, done_en;
  pps_pkg::res_t res_nxt;

  assign e_used   = used_r[idx_r];
  assign e_job    = job_r[idx_r];
  assign e_arr    = arr_r[idx_r];
  assign e_pri    = pri_r[idx_r];
  assign e_left   = left_r[idx_r];
  assign e_arr32  = {16'd0, e_arr};
  assign need_age = (period_r != 10'd0) && e_used && (now_r > e_arr32);
  assign last     = (idx_r == IW'(JOB_SLOTS - 1));
  assign out_free = !res_v_r || out_pop;
  assign load_ok  = (9'(q_data.slot) < 9'(JOB_SLOTS));

  // Aging and candidate compare
  always_comb begin
    e_pri_aged = e_pri;
    if (state_r == pps_pkg::ST_MOD && rs.rem == 10'd0 && e_pri != 8'd0) begin
      e_pri_aged = e_pri - 8'd1;
    end
    ready   = e_used && (e_left != 16'd0) && (e_arr32 <= now_r);
    waiting = e_used && (e_left != 16'd0) && (e_arr32 > now_r);
    better  = !found_r || (e_pri_aged < b_pri_r) ||
              (e_pri_aged == b_pri_r && e_arr < b_arr_r) ||
              (e_pri_aged == b_pri_r && e_arr == b_arr_r && e_job < b_job_r);
  end

  // Next state and control
  always_comb begin
    state_nxt   = state_r;
    q_pop       = 1'b0;
    rq.start    = 1'b0;
    rq.dividend = now_r - e_arr32;
    rq.divisor  = period_r;
    eval_en     = 1'b0;
    load_en     = 1'b0;
    done_en     = 1'b0;
    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.req_type == pps_pkg::REQ_LOAD) load_en = 1'b1;
          else state_nxt = pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (need_age) begin
          rq.start  = 1'b1;
          state_nxt = pps_pkg::ST_MOD;
        end else begin
          eval_en   = 1'b1;
          state_nxt = last ? pps_pkg::ST_DONE : pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_MOD: begin
        if (rs.done) begin
          eval_en   = 1'b1;
          state_nxt = last ? pps_pkg::ST_DONE : pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_DONE: begin
        if (out_free) begin
          done_en   = 1'b1;
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pps_pkg::ST_IDLE;
    endcase
  end

  // Tick result
  always_comb begin
    finished = !found_r && !pending_r;
    frame    = cur_v_r && (!found_r || b_slot_r != cur_slot_r);
    res_nxt.frame_valid   = frame;
    res_nxt.frame_job     = frame ? c_job_r : 16'd0;
    res_nxt.frame_arrival = frame ? c_arr_r : 16'd0;
    res_nxt.frame_start   = frame ? began_r : 32'd0;
    res_nxt.frame_end     = frame ? now_r : 32'd0;
    res_nxt.frame_length  = frame ? (now_r - began_r) : 32'd0;
    res_nxt.running_valid = found_r;
    res_nxt.running_job   = found_r ? b_job_r : 16'd0;
    res_nxt.all_done      = finished;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pps_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Table payload
  always_ff @(posedge clk) begin
    if (load_en && load_ok) begin
      job_r[IW'(q_data.slot)]  <= q_data.job_id;
      arr_r[IW'(q_data.slot)]  <= q_data.arrival_time;
      pri_r[IW'(q_data.slot)]  <= q_data.start_priority;
      left_r[IW'(q_data.slot)] <= q_data.burst_length;
    end
    if (eval_en) pri_r[idx_r] <= e_pri_aged;
    if (done_en && found_r) left_r[b_slot_r] <= left_r[b_slot_r] - 16'd1;
  end

  // Scan accumulators
  always_ff @(posedge clk) begin
    if (state_r == pps_pkg::ST_IDLE) begin
      found_r   <= 1'b0;
      pending_r <= 1'b0;
    end else if (eval_en) begin
      if (ready && better) begin
        found_r  <= 1'b1;
        b_slot_r <= idx_r;
        b_pri_r  <= e_pri_aged;
        b_arr_r  <= e_arr;
        b_job_r  <= e_job;
      end
      if (waiting) pending_r <= 1'b1;
      if (idx_r == cur_slot_r) begin
        c_job_r <= e_job;
        c_arr_r <= e_arr;
      end
    end
    if (done_en) res_r <= res_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      period_r   <= pps_pkg::AGE_RESET;
      now_r      <= 32'd0;
      cur_v_r    <= 1'b0;
      cur_slot_r <= '0;
      began_r    <= 32'd0;
      idx_r      <= '0;
      res_v_r    <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (load_en && load_ok) used_r[IW'(q_data.slot)] <= 1'b1;
      if (state_r == pps_pkg::ST_IDLE) idx_r <= '0;
      else if (eval_en && !last) idx_r <= idx_r + IW'(1);
      if (out_pop) res_v_r <= 1'b0;
      if (done_en) begin
        res_v_r <= 1'b1;
        now_r   <= now_r + 32'd1;
        if (frame) cur_v_r <= 1'b0;
        if (found_r && (!cur_v_r || frame)) begin
          cur_v_r    <= 1'b1;
          cur_slot_r <= b_slot_r;
          began_r    <= now_r;
        end
      end
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

endmodule

FILE: design/preemptive_priority_aging_scheduler_core.sv
`timescale 1ns / 1ps

// Preemptive priority scheduler with aging over a table of JOB_SLOTS job slots.
// Requests enter a two-entry queue (push/full); results leave through a
// one-entry result register (empty/pop), one result per tick request and none
// per load. A tick scans the table one slot per cycle, except that a slot
// whose aging must be tested first waits on the shared remainder unit (four
// dividend bits per cycle). A tick also waits while the previous result has
// not been popped. aging_period resets to 20; zero turns aging off.
module preemptive_priority_aging_scheduler_core #(
  parameter int unsigned JOB_SLOTS = pps_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_arrival_time,
  input  logic [7:0]  in_start_priority,
  input  logic [15:0] in_burst_length,
  output logic        empty,
  input  logic        pop,
  output logic        out_frame_valid,
  output logic [15:0] out_frame_job,
  output logic [15:0] out_frame_arrival,
  output logic [31:0] out_frame_start,
  output logic [31:0] out_frame_end,
  output logic [31:0] out_frame_length,
  output logic        out_running_valid,
  output logic [15:0] out_running_job,
  output logic        out_all_done
);

  pps_pkg::req_t req_in, q_data;
  pps_pkg::res_t res;
  logic          q_valid, q_pop, out_valid;

  assign req_in.req_type       = in_req_type;
  assign req_in.slot           = in_slot;
  assign req_in.job_id         = in_job_id;
  assign req_in.arrival_time   = in_arrival_time;
  assign req_in.start_priority = in_start_priority;
  assign req_in.burst_length   = in_burst_length;

  pps_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_in(req_in),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  pps_back #(.JOB_SLOTS(JOB_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_pop(pop), .out_data(res)
  );

  assign empty             = !out_valid;
  assign out_frame_valid   = res.frame_valid;
  assign out_frame_job     = res.frame_job;
  assign out_frame_arrival = res.frame_arrival;
  assign out_frame_start   = res.frame_start;
  assign out_frame_end     = res.frame_end;
  assign out_frame_length  = res.frame_length;
  assign out_running_valid = res.running_valid;
  assign out_running_job   = res.running_job;
  assign out_all_done      = res.all_done;

endmodule

FILE: sim/preemptive_priority_aging_scheduler_core_tb.sv
`timescale 1ns / 1ps

module preemptive_priority_aging_scheduler_core_tb;

  localparam int NSLOT = 16;
  localparam int RAND_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic        in_req_type = pps_pkg::REQ_TICK;
  logic [3:0]  in_slot = '0;
  logic [15:0] in_job_id = '0;
  logic [15:0] in_arrival_time = '0;
  logic [7:0]  in_start_priority = '0;
  logic [15:0] in_burst_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_frame_valid;
  logic [15:0] out_frame_job;
  logic [15:0] out_frame_arrival;
  logic [31:0] out_frame_start;
  logic [31:0] out_frame_end;
  logic [31:0] out_frame_length;
  logic        out_running_valid;
  logic [15:0] out_running_job;
  logic        out_all_done;

  preemptive_priority_aging_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_req_type(in_req_type), .in_slot(in_slot),
    .in_job_id(in_job_id), .in_arrival_time(in_arrival_time),
    .in_start_priority(in_start_priority), .in_burst_length(in_burst_length),
    .empty(empty), .pop(pop), .out_frame_valid(out_frame_valid),
    .out_frame_job(out_frame_job), .out_frame_arrival(out_frame_arrival),
    .out_frame_start(out_frame_start), .out_frame_end(out_frame_end),
    .out_frame_length(out_frame_length), .out_running_valid(out_running_valid),
    .out_running_job(out_running_job), .out_all_done(out_all_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scheduler shadow state
  logic [9:0]  age_period;
  logic        sh_used [NSLOT];
  logic [15:0] sh_job [NSLOT];
  logic [15:0] sh_arr [NSLOT];
  logic [7:0]  sh_prio [NSLOT];
  logic [15:0] sh_left [NSLOT];
  logic [31:0] sh_now;
  logic        sh_cur_valid;
  int          sh_cur;
  logic [31:0] sh_began;

  pps_pkg::res_t tick_results[$];
  int   errors = 0;
  int   n_pushed = 0;
  int   n_popped = 0;
  int   n_frames = 0;
  longint cycles = 0;
  bit   idle_ok = 1'b1;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  function automatic bit outranks(int a, int b);
    if (sh_prio[a] != sh_prio[b]) return sh_prio[a] < sh_prio[b];
    if (sh_arr[a] != sh_arr[b]) return sh_arr[a] < sh_arr[b];
    if (sh_job[a] != sh_job[b]) return sh_job[a] < sh_job[b];
    return a < b;
  endfunction

  // Apply one accepted request; a tick queues the expected result
  task automatic schedule_step(pps_pkg::req_t r);
    pps_pkg::res_t e;
    int pick;
    bit found, pending;
    pick = 0; found = 0; pending = 0;
    e = '0;
    if (r.req_type == pps_pkg::REQ_LOAD) begin
      sh_used[r.slot] = 1'b1;
      sh_job[r.slot] = r.job_id;
      sh_arr[r.slot] = r.arrival_time;
      sh_prio[r.slot] = r.start_priority;
      sh_left[r.slot] = r.burst_length;
      return;
    end
    // aging
    if (age_period != 0) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (sh_used[i] && sh_now > {16'd0, sh_arr[i]} &&
            (sh_now - {16'd0, sh_arr[i]}) % age_period == 0 && sh_prio[i] != 0)
          sh_prio[i]--;
      end
    end
    // pick best ready job
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_used[i] || sh_left[i] == 0) continue;
      if ({16'd0, sh_arr[i]} <= sh_now) begin
        if (!found || outranks(i, pick)) begin
          pick = i;
          found = 1;
        end
      end else begin
        pending = 1;
      end
    end
    e.all_done = !found && !pending;
    if (sh_cur_valid && (!found || pick != sh_cur)) begin
      e.frame_valid = 1'b1;
      e.frame_job = sh_job[sh_cur];
      e.frame_arrival = sh_arr[sh_cur];
      e.frame_start = sh_began;
      e.frame_end = sh_now;
      e.frame_length = sh_now - sh_began;
      sh_cur_valid = 1'b0;
    end
    if (found) begin
      if (!sh_cur_valid) begin
        sh_cur_valid = 1'b1;
        sh_cur = pick;
        sh_began = sh_now;
      end
      sh_left[pick]--;
      e.running_valid = 1'b1;
      e.running_job = sh_job[pick];
    end
    sh_now++;
    tick_results.push_back(e);
  endtask

  // Send one request, waiting for full to drop; push stays high afterwards
  task automatic send_req(pps_pkg::req_t r);
    while (idle_ok && $urandom_range(99) < 28) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_req_type <= r.req_type;
    in_slot <= r.slot;
    in_job_id <= r.job_id;
    in_arrival_time <= r.arrival_time;
    in_start_priority <= r.start_priority;
    in_burst_length <= r.burst_length;
    @(posedge clk);
    while (full) @(posedge clk);
    schedule_step(r);
    n_pushed++;
    @(negedge clk);
  endtask

  task automatic write_period(logic [9:0] p);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    age_period = p;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (tick_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic pps_pkg::req_t mk_load(int s, int id, int arr, int pr, int bl);
    pps_pkg::req_t r;
    r.req_type = pps_pkg::REQ_LOAD;
    r.slot = s[3:0];
    r.job_id = id[15:0];
    r.arrival_time = arr[15:0];
    r.start_priority = pr[7:0];
    r.burst_length = bl[15:0];
    return r;
  endfunction

  function automatic pps_pkg::req_t mk_tick();
    pps_pkg::req_t r;
    r = '0;
    r.req_type = pps_pkg::REQ_TICK;
    r.slot = 4'($urandom());
    r.job_id = 16'($urandom());
    r.arrival_time = 16'($urandom());
    r.start_priority = 8'($urandom());
    r.burst_length = 16'($urandom());
    return r;
  endfunction

  // Directed table; the first row's result is known at a glance
  typedef struct {
    pps_pkg::req_t r;
    bit            has_fixed;
    pps_pkg::res_t fixed;
  } row_t;

  row_t dir_rows[$];

  // Result checker
  always @(posedge clk) begin
    pps_pkg::res_t e;
    if (rst_n && pop && !empty) begin
      n_popped++;
      if (out_frame_valid) n_frames++;
      if (tick_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = tick_results.pop_front();
        if (out_frame_valid !== e.frame_valid) begin
          $error("frame_valid exp %0h got %0h", e.frame_valid, out_frame_valid); errors++;
        end
        if (out_frame_job !== e.frame_job) begin
          $error("frame_job exp %0h got %0h", e.frame_job, out_frame_job); errors++;
        end
        if (out_frame_arrival !== e.frame_arrival) begin
          $error("frame_arrival exp %0h got %0h", e.frame_arrival, out_frame_arrival);
          errors++;
        end
        if (out_frame_start !== e.frame_start) begin
          $error("frame_start exp %0h got %0h", e.frame_start, out_frame_start); errors++;
        end
        if (out_frame_end !== e.frame_end) begin
          $error("frame_end exp %0h got %0h", e.frame_end, out_frame_end); errors++;
        end
        if (out_frame_length !== e.frame_length) begin
          $error("frame_length exp %0h got %0h", e.frame_length, out_frame_length);
          errors++;
        end
        if (out_running_valid !== e.running_valid) begin
          $error("running_valid exp %0h got %0h", e.running_valid, out_running_valid);
          errors++;
        end
        if (out_running_job !== e.running_job) begin
          $error("running_job exp %0h got %0h", e.running_job, out_running_job); errors++;
        end
        if (out_all_done !== e.all_done) begin
          $error("all_done exp %0h got %0h", e.all_done, out_all_done); errors++;
        end
      end
    end
  end

  // Pop driver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_off) pop <= 1'b0;
    else pop <= !(idle_ok && $urandom_range(99) < 28);
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("preemptive_priority_aging_scheduler_core_tb failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted in its own process
  initial begin
    wait (n_pushed > 300);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    row_t w;
    pps_pkg::res_t e;
    pps_pkg::req_t r;
    int phase;
    age_period = pps_pkg::AGE_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      sh_used[i] = 0; sh_job[i] = 0; sh_arr[i] = 0; sh_prio[i] = 0; sh_left[i] = 0;
    end
    sh_now = 0; sh_cur_valid = 0; sh_cur = 0; sh_began = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table tick gives all_done, then extremes and ties
    w.r = mk_tick(); w.has_fixed = 1; e = '0; e.all_done = 1'b1; w.fixed = e;
    dir_rows.push_back(w);
    w.has_fixed = 0;
    w.r = mk_load(0, 16'hFFFF, 0, 8'hFF, 3); dir_rows.push_back(w);
    w.r = mk_load(15, 0, 0, 0, 2); dir_rows.push_back(w);
    w.r = mk_load(1, 5, 2, 0, 2); dir_rows.push_back(w);
    w.r = mk_load(2, 5, 2, 0, 1); dir_rows.push_back(w);       // full tie, slot decides
    w.r = mk_load(3, 9, 16'hFFFF, 0, 16'hFFFF); dir_rows.push_back(w); // far future
    w.r = mk_load(4, 7, 1, 3, 0); dir_rows.push_back(w);       // zero burst
    for (int k = 0; k < 8; k++) begin
      w.r = mk_tick(); dir_rows.push_back(w);
    end
    w.r = mk_load(0, 16'h1234, 0, 1, 2); dir_rows.push_back(w); // reload running slot
    for (int k = 0; k < 6; k++) begin
      w.r = mk_tick(); dir_rows.push_back(w);
    end
    foreach (dir_rows[k]) begin
      if (dir_rows[k].has_fixed) begin
        r = dir_rows[k].r;
        send_req(r);
        // predictor must agree with the typed-in value
        if (tick_results[$] !== dir_rows[k].fixed) begin
          $error("tick result exp %0h got %0h", dir_rows[k].fixed, tick_results[$]);
          errors++;
        end
      end else begin
        send_req(dir_rows[k].r);
      end
    end
    drain_results();

    // Random phases across aging settings, extremes included
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_period(10'd1);
        1: write_period(10'd0);
        2: write_period(10'd1023);
        3: write_period(10'($urandom_range(2, 8)));
        4: write_period(10'($urandom_range(1, 1023)));
        default: write_period(10'd3);
      endcase
      idle_ok = (phase != 2);
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        if ($urandom_range(99) < 25) begin
          // arrivals mostly near the current tick so jobs become ready
          if ($urandom_range(9) == 0)
            r = mk_load($urandom_range(15), $urandom(), $urandom(), $urandom(), $urandom());
          else
            r = mk_load($urandom_range(15), $urandom_range(0, 7),
                        sh_now[15:0] + $urandom_range(0, 6), $urandom_range(0, 4),
                        $urandom_range(0, 5));
        end else begin
          r = mk_tick();
        end
        send_req(r);
      end
      drain_results();
    end
    idle_ok = 1'b1;

    drain_results();
    $display("covered %0d requests, %0d ticks popped, %0d run frames", n_pushed,
             n_popped, n_frames);
    $display("aging periods 0, 1, 1023 and random, with a long output stall");
    if (errors == 0 && tick_results.size() == 0) begin
      $display("preemptive_priority_aging_scheduler_core_tb passed");
    end else begin
      $display("preemptive_priority_aging_scheduler_core_tb failed");
    end
    $finish;
  end

endmodule

FILE: preemptive_priority_aging_scheduler_core.f
design/pps_pkg.sv
design/pps_front.sv
design/pps_rem.sv
design/pps_back.sv
design/preemptive_priority_aging_scheduler_core.sv
sim/preemptive_priority_aging_scheduler_core_tb.sv
